// ===== rtl/lcsp_pkg.sv =====
// Shared codes, widths and constants for the lane-change speed planner.
package lcsp_pkg;

  // Request operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CAR    = 2'd1;
  localparam logic [1:0] OP_DECIDE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPEED_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_VELOCITY_STEP = 2'd1;
  localparam logic [1:0] CFG_GAP_DISTANCE  = 2'd2;
  localparam int unsigned CFG_DATA_W = 17;

  // Configuration reset values
  localparam logic [16:0] SPEED_LIMIT_RST   = 17'd49500;
  localparam logic [11:0] VELOCITY_STEP_RST = 12'd428;
  localparam logic [7:0]  GAP_DISTANCE_RST  = 8'd30;

  // Shared multiplier
  localparam int unsigned MUL_W  = 25;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Root unit: 48-bit radicand, 24-bit root, two radicand bits per step
  localparam int unsigned RT_IN_W = 48;
  localparam int unsigned RT_W    = RT_IN_W / 2;

  // Division by 50 through a reciprocal: q0 = (r * RECIP_M) >> RECIP_SH, then one correction
  localparam int unsigned RECIP_SH = 30;
  localparam logic [MUL_W-1:0] RECIP_M = 25'd21474836;
  localparam logic [MUL_W-1:0] DIV_BY  = 25'd50;
  localparam int unsigned Q_W = 19;

  // m/s against milli-mph, compared in squares
  localparam logic [MUL_W-1:0] MILLION_SQ = 25'd1000000;
  localparam int unsigned SQ_CMP_W = 35;

  // Reference velocity limits
  localparam logic [17:0] VEL_MAX = 18'h1FFFF;
  localparam logic [17:0] VEL_MIN = 18'h20000;

endpackage

// ===== rtl/lcsp_isqrt.sv =====
// Iterative integer square root, one root bit per cycle.
module lcsp_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lcsp_pkg::RT_IN_W-1:0]  radicand,
  output logic                          busy,
  output logic [lcsp_pkg::RT_W-1:0]     root
);

  localparam int unsigned CNT_W = $clog2(lcsp_pkg::RT_W);

  logic [lcsp_pkg::RT_IN_W-1:0] x_r, x_nxt;
  logic [lcsp_pkg::RT_W+1:0]    rem_r, rem_nxt;
  logic [lcsp_pkg::RT_W-1:0]    root_r, root_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic [lcsp_pkg::RT_W+1:0]    rem_t;
  logic [lcsp_pkg::RT_W+1:0]    trial;

  // Bring down the next two radicand bits and try the new root bit
  assign rem_t = {rem_r[lcsp_pkg::RT_W-1:0], x_r[lcsp_pkg::RT_IN_W-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start && !busy_r) begin
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[lcsp_pkg::RT_IN_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_r[lcsp_pkg::RT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_r[lcsp_pkg::RT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(lcsp_pkg::RT_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== rtl/lane_change_speed_planner.sv =====
// Top level of the lane-change speed planner: sequencer, frame state and shared multiplier.
//
// A frame is a start request (ego position and leftover path points; clears the three
// lane-occupied marks), any number of car requests, and a decide request that returns one
// result: the chosen lane, the new reference velocity in milli-mph and the occupied mask.
// Start requests and requests with an unused operation code are handled in the idle state.
// For a car request, passes through the shared 25x25 multiplier build the squared speed and
// the projection radicand, the root unit then produces one root bit per cycle (the speed
// compare and the behind test run under it), a wait state notes that the root is done, and
// the root is divided by 50, the quotient is corrected and the lane is marked.
// A decide request squares the raised velocity, scales the capped squared speed and then
// waits until the result register is free; start and car requests are still taken while an
// earlier result waits to be collected. The block accepts one request at a time (in_ready is
// low while a request is at work). The configuration port is always ready and is meant to be
// written only while the block idles. There is no clearing pass after reset.
module lane_change_speed_planner (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic [5:0]                         in_prev_points,
  input  logic [22:0]                        in_ego_s,
  input  logic signed [7:0]                  in_other_vx,
  input  logic signed [7:0]                  in_other_vy,
  input  logic [12:0]                        in_other_s,
  input  logic signed [6:0]                  in_other_d,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_next_lane,
  output logic signed [17:0]                 out_next_velocity,
  output logic [2:0]                         out_occupied_mask,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [lcsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CSQX  = 4'd1;   // vx squared
  localparam logic [3:0] S_CSQY  = 4'd2;   // vy squared
  localparam logic [3:0] S_CP2   = 4'd3;   // points squared
  localparam logic [3:0] S_CX    = 4'd4;   // squared speed times points squared
  localparam logic [3:0] S_CRT   = 4'd5;   // launch root, square the speed bound
  localparam logic [3:0] S_CLIM  = 4'd6;   // hold bound square, scale squared speed
  localparam logic [3:0] S_CSQM  = 4'd7;   // speed compare, behind test
  localparam logic [3:0] S_CWAIT = 4'd8;   // wait for the root
  localparam logic [3:0] S_CDIV  = 4'd9;   // root times reciprocal of 50
  localparam logic [3:0] S_CQ    = 4'd10;  // quotient estimate times 50
  localparam logic [3:0] S_CCOR  = 4'd11;  // correct the quotient
  localparam logic [3:0] S_CMARK = 4'd12;  // ahead test and lane mark
  localparam logic [3:0] S_DSQ1  = 4'd13;  // square the raised velocity
  localparam logic [3:0] S_DSQ2  = 4'd14;  // scale the capped squared speed
  localparam logic [3:0] S_DFIN  = 4'd15;  // decide and load the result register

  localparam int unsigned MW = lcsp_pkg::MUL_W;
  localparam int unsigned PW = lcsp_pkg::PROD_W;
  localparam int unsigned RW = lcsp_pkg::RT_W;
  localparam int unsigned QW = lcsp_pkg::Q_W;
  localparam int unsigned CW = lcsp_pkg::SQ_CMP_W;

  logic [3:0]  state_r, state_nxt;

  // Configuration registers
  logic [16:0] speed_limit_r;
  logic [11:0] velocity_step_r;
  logic [7:0]  gap_distance_r;

  // Architectural state
  logic [1:0]  cur_lane_r, cur_lane_nxt;
  logic [17:0] ref_vel_r, ref_vel_nxt;
  logic [15:0] capped_sq_r, capped_sq_nxt;
  logic [2:0]  lane_marks_r, lane_marks_nxt;
  logic [22:0] frame_ego_s_r;
  logic [5:0]  frame_points_r;

  // Car request payload
  logic [7:0]        vx_r, vy_r;
  logic [12:0]       s_r;
  logic signed [6:0] d_r;

  // Working registers
  logic [PW-1:0]  prod_r;
  logic [15:0]    sq_r, sq_nxt;
  logic [CW-1:0]  bsq_r, bsq_nxt;
  logic           below_r, below_nxt;
  logic           behind_r, behind_nxt;
  logic [2:0]     lane_hit_r, lane_hit_nxt;
  logic [QW-1:0]  q0_r, q0_nxt;
  logic [QW-1:0]  q_r, q_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_lane_r, out_lane_nxt;
  logic [17:0] out_vel_r, out_vel_nxt;
  logic [2:0]  out_mask_r, out_mask_nxt;

  // Shared multiplier operands
  logic [MW-1:0] mul_a, mul_b;

  // Root unit hookup
  logic                            rt_start;
  logic [lcsp_pkg::RT_IN_W-1:0]    rt_radicand;
  logic                            rt_busy;
  logic [RW-1:0]                   rt_root;

  logic        in_acc;
  logic [7:0]  vx_mag, vy_mag;
  logic [18:0] vel_up;         // ref velocity plus step, signed
  logic [18:0] vel_dn;         // ref velocity minus step, signed
  logic        up_pos;
  logic [22:0] pos;
  logic [23:0] proj;
  logic [24:0] ahead_diff;
  logic [23:0] behind_diff;
  logic        ahead;
  logic [RW-1:0] rem_w;

  // Decide terms
  logic        own_blocked, left_free, right_free;
  logic        up_ok, follow_up;
  logic [18:0] vel_pick;
  logic [1:0]  lane_pick;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign vx_mag = vx_r[7] ? (~vx_r + 8'd1) : vx_r;
  assign vy_mag = vy_r[7] ? (~vy_r + 8'd1) : vy_r;

  assign vel_up = {ref_vel_r[17], ref_vel_r} + {7'b0, velocity_step_r};
  assign vel_dn = {ref_vel_r[17], ref_vel_r} - {7'b0, velocity_step_r};
  assign up_pos = !vel_up[18] && (vel_up != '0);

  assign pos  = {s_r, 10'b0};
  assign proj = {1'b0, pos} + {{(24-QW){1'b0}}, q_r};
  assign ahead_diff  = {1'b0, proj} - {2'b0, frame_ego_s_r};
  assign behind_diff = {1'b0, frame_ego_s_r} - {1'b0, pos};
  assign ahead = !ahead_diff[24] && (ahead_diff != '0)
              && (ahead_diff[23:0] < {6'b0, gap_distance_r, 10'b0}) && below_r;

  assign rem_w = rt_root - prod_r[RW-1:0];

  assign rt_start    = (state_r == S_CRT);
  assign rt_radicand = {prod_r[27:0], 20'b0};

  lcsp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (rt_radicand),
    .busy     (rt_busy),
    .root     (rt_root)
  );

  // Route the multiplier operands for each step of the sequence
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r) inside
      S_CSQX: begin
        mul_a = {{(MW-8){1'b0}}, vx_mag};
        mul_b = {{(MW-8){1'b0}}, vx_mag};
      end
      S_CSQY: begin
        mul_a = {{(MW-8){1'b0}}, vy_mag};
        mul_b = {{(MW-8){1'b0}}, vy_mag};
      end
      S_CP2: begin
        mul_a = {{(MW-6){1'b0}}, frame_points_r};
        mul_b = {{(MW-6){1'b0}}, frame_points_r};
      end
      S_CX: begin
        mul_a = {{(MW-16){1'b0}}, sq_r};
        mul_b = {{(MW-12){1'b0}}, prod_r[11:0]};
      end
      S_CRT, S_DSQ1: begin
        mul_a = {{(MW-18){1'b0}}, vel_up[17:0]};
        mul_b = {{(MW-18){1'b0}}, vel_up[17:0]};
      end
      S_CLIM: begin
        mul_a = {{(MW-16){1'b0}}, sq_r};
        mul_b = lcsp_pkg::MILLION_SQ;
      end
      S_CDIV: begin
        mul_a = {{(MW-RW){1'b0}}, rt_root};
        mul_b = lcsp_pkg::RECIP_M;
      end
      S_CQ: begin
        mul_a = {{(MW-QW){1'b0}}, prod_r[lcsp_pkg::RECIP_SH +: QW]};
        mul_b = lcsp_pkg::DIV_BY;
      end
      S_DSQ2, S_DFIN: begin
        mul_a = {{(MW-16){1'b0}}, capped_sq_r};
        mul_b = lcsp_pkg::MILLION_SQ;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Lane rule: stay, go left, go right, follow the capped speed, or slow down
  always_comb begin
    unique case (cur_lane_r)
      2'd0: begin
        own_blocked = lane_marks_r[0];
        left_free   = 1'b0;
        right_free  = !lane_marks_r[1];
      end
      2'd1: begin
        own_blocked = lane_marks_r[1];
        left_free   = !lane_marks_r[0];
        right_free  = !lane_marks_r[2];
      end
      default: begin
        own_blocked = lane_marks_r[2];
        left_free   = !lane_marks_r[1];
        right_free  = 1'b0;
      end
    endcase

    up_ok     = $signed(vel_up) < $signed({2'b0, speed_limit_r});
    follow_up = vel_up[18] || (bsq_r < prod_r[CW-1:0]);
    vel_pick  = {ref_vel_r[17], ref_vel_r};
    lane_pick = cur_lane_r;

    if (!own_blocked) begin
      if (up_ok) vel_pick = vel_up;
    end else if (left_free) begin
      if (up_ok) vel_pick = vel_up;
      lane_pick = cur_lane_r - 2'd1;
    end else if (right_free) begin
      if (up_ok) vel_pick = vel_up;
      lane_pick = cur_lane_r + 2'd1;
    end else if (lane_marks_r == 3'b111) begin
      vel_pick = follow_up ? vel_up : vel_dn;
    end else begin
      vel_pick = vel_dn;
    end
  end

  // Sequencer and state updates
  always_comb begin
    state_nxt      = state_r;
    cur_lane_nxt   = cur_lane_r;
    ref_vel_nxt    = ref_vel_r;
    capped_sq_nxt  = capped_sq_r;
    lane_marks_nxt = lane_marks_r;
    sq_nxt         = sq_r;
    bsq_nxt        = bsq_r;
    below_nxt      = below_r;
    behind_nxt     = behind_r;
    lane_hit_nxt   = lane_hit_r;
    q0_nxt         = q0_r;
    q_nxt          = q_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_lane_nxt   = out_lane_r;
    out_vel_nxt    = out_vel_r;
    out_mask_nxt   = out_mask_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            lcsp_pkg::OP_START:  lane_marks_nxt = '0;
            lcsp_pkg::OP_CAR:    state_nxt = S_CSQX;
            lcsp_pkg::OP_DECIDE: state_nxt = S_DSQ1;
            default: ;
          endcase
        end
      end
      S_CSQX: state_nxt = S_CSQY;
      S_CSQY: begin
        sq_nxt    = prod_r[15:0];
        state_nxt = S_CP2;
      end
      S_CP2: begin
        sq_nxt    = sq_r + prod_r[15:0];
        state_nxt = S_CX;
      end
      S_CX: state_nxt = S_CRT;
      S_CRT: state_nxt = S_CLIM;
      S_CLIM: begin
        bsq_nxt   = prod_r[CW-1:0];
        state_nxt = S_CSQM;
      end
      S_CSQM: begin
        below_nxt    = up_pos && (prod_r[CW-1:0] < bsq_r);
        behind_nxt   = !behind_diff[23]
                    && (behind_diff[22:0] < {5'b0, gap_distance_r, 10'b0});
        lane_hit_nxt = {(d_r > 7'sd8) && (d_r < 7'sd12),
                        (d_r > 7'sd4) && (d_r < 7'sd8),
                        (d_r > 7'sd0) && (d_r < 7'sd4)};
        state_nxt    = S_CWAIT;
      end
      S_CWAIT: begin
        if (!rt_busy) state_nxt = S_CDIV;
      end
      S_CDIV: state_nxt = S_CQ;
      S_CQ: begin
        q0_nxt    = prod_r[lcsp_pkg::RECIP_SH +: QW];
        state_nxt = S_CCOR;
      end
      S_CCOR: begin
        // Estimate is exact or one short
        q_nxt     = q0_r + QW'(rem_w >= RW'(lcsp_pkg::DIV_BY));
        state_nxt = S_CMARK;
      end
      S_CMARK: begin
        if ((lane_hit_r != '0) && (ahead || behind_r)) begin
          lane_marks_nxt = lane_marks_r | lane_hit_r;
          capped_sq_nxt  = sq_r;
        end
        state_nxt = S_IDLE;
      end
      S_DSQ1: state_nxt = S_DSQ2;
      S_DSQ2: begin
        bsq_nxt   = prod_r[CW-1:0];
        state_nxt = S_DFIN;
      end
      S_DFIN: begin
        // Hold the decision until the result register is free
        if (!out_valid_r || out_ready) begin
          if (vel_pick[18] != vel_pick[17]) begin
            ref_vel_nxt = vel_pick[18] ? lcsp_pkg::VEL_MIN : lcsp_pkg::VEL_MAX;
          end else begin
            ref_vel_nxt = vel_pick[17:0];
          end
          cur_lane_nxt  = lane_pick;
          out_valid_nxt = 1'b1;
          out_lane_nxt  = lane_pick;
          out_vel_nxt   = ref_vel_nxt;
          out_mask_nxt  = lane_marks_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      speed_limit_r   <= lcsp_pkg::SPEED_LIMIT_RST;
      velocity_step_r <= lcsp_pkg::VELOCITY_STEP_RST;
      gap_distance_r  <= lcsp_pkg::GAP_DISTANCE_RST;
      cur_lane_r      <= 2'd1;
      ref_vel_r       <= '0;
      capped_sq_r     <= '0;
      lane_marks_r    <= '0;
      frame_ego_s_r   <= '0;
      frame_points_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_lane_r   <= cur_lane_nxt;
      ref_vel_r    <= ref_vel_nxt;
      capped_sq_r  <= capped_sq_nxt;
      lane_marks_r <= lane_marks_nxt;
      out_valid_r  <= out_valid_nxt;
      if (in_acc && (in_op == lcsp_pkg::OP_START)) begin
        frame_ego_s_r  <= in_ego_s;
        frame_points_r <= in_prev_points;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lcsp_pkg::CFG_SPEED_LIMIT:   speed_limit_r   <= cfg_data;
          lcsp_pkg::CFG_VELOCITY_STEP: velocity_step_r <= cfg_data[11:0];
          lcsp_pkg::CFG_GAP_DISTANCE:  gap_distance_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and working registers carry no reset
  always_ff @(posedge clk) begin
    if (in_acc && (in_op == lcsp_pkg::OP_CAR)) begin
      vx_r <= in_other_vx;
      vy_r <= in_other_vy;
      s_r  <= in_other_s;
      d_r  <= in_other_d;
    end
    sq_r       <= sq_nxt;
    bsq_r      <= bsq_nxt;
    below_r    <= below_nxt;
    behind_r   <= behind_nxt;
    lane_hit_r <= lane_hit_nxt;
    q0_r       <= q0_nxt;
    q_r        <= q_nxt;
    out_lane_r <= out_lane_nxt;
    out_vel_r  <= out_vel_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_next_lane     = out_lane_r;
  assign out_next_velocity = out_vel_r;
  assign out_occupied_mask = out_mask_r;

  // A result only appears from the decide step
  a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DFIN))
    else $error("result raised outside the decide step");

  // The root must still be running when its result is not yet due
  a_root_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLIM) |-> rt_busy)
    else $error("root unit idle while a car request needs it");

  // Marks change only on a start request or at the marking step
  a_marks_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CMARK && !(in_acc && in_op == lcsp_pkg::OP_START))
      |=> $stable(lane_marks_r))
    else $error("lane marks changed outside start or marking");

  // A blocked result register keeps the decide step waiting
  a_decide_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DFIN && out_valid_r && !out_ready) |=> (state_r == S_DFIN))
    else $error("decide step left while the result register was full");

endmodule

// ===== verif/lane_change_speed_planner_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the lane-change speed planner: directed frames, rails and random traffic.
module lane_change_speed_planner_tb;

  // Codes the package leaves out: the spare operation and the spare register index
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Margin for a car request still at work to finish before touching the registers
  localparam int SETTLE_CYCLES = 40;
  // Longest legal stretch without any handshake is the receiver hold-off
  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLDOFF_LEN   = 500;
  localparam int ITEM_TARGET   = 1750;
  localparam int MAX_PRINTED   = 30;

  localparam longint VEL_TOP    = 131071;
  localparam longint VEL_BOTTOM = -131072;

  typedef struct {
    logic [1:0]        op;
    logic [5:0]        points;
    logic [22:0]       ego_s;
    logic signed [7:0] vx;
    logic signed [7:0] vy;
    logic [12:0]       other_s;
    logic signed [6:0] other_d;
  } request_t;

  typedef struct {
    logic [1:0]         lane;
    logic signed [17:0] velocity;
    logic [2:0]         mask;
  } plan_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_op;
  logic [5:0]            in_prev_points;
  logic [22:0]           in_ego_s;
  logic signed [7:0]     in_other_vx;
  logic signed [7:0]     in_other_vy;
  logic [12:0]           in_other_s;
  logic signed [6:0]     in_other_d;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_next_lane;
  logic signed [17:0]    out_next_velocity;
  logic [2:0]            out_occupied_mask;

  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [lcsp_pkg::CFG_DATA_W-1:0] cfg_data;

  lane_change_speed_planner DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_prev_points    (in_prev_points),
    .in_ego_s          (in_ego_s),
    .in_other_vx       (in_other_vx),
    .in_other_vy       (in_other_vy),
    .in_other_s        (in_other_s),
    .in_other_d        (in_other_d),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_lane     (out_next_lane),
    .out_next_velocity (out_next_velocity),
    .out_occupied_mask (out_occupied_mask),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Planner state as the testbench sees it: registers, frame latches, lane marks
  // ---------------------------------------------------------------------------
  logic [16:0]        lim_cfg;
  logic [11:0]        step_cfg;
  logic [7:0]         gap_cfg;
  logic [1:0]         cur_lane;
  logic signed [17:0] ref_vel;
  logic [15:0]        cap_sq;
  logic [2:0]         marks;
  logic [22:0]        frame_ego;
  logic [5:0]         frame_pts;

  // Plans owed by accepted decide requests, oldest first
  plan_t pending_plans[$];
  plan_t head_plan;

  int mismatches      = 0;
  int items_sent      = 0;
  int burst_left      = 0;
  bit offering        = 1'b0;
  int idle_cycles     = 0;
  int holdoff_request = 0;
  int holdoff_left    = 0;
  int rx_stretch      = 0;
  rx_mode_t rx_mode   = RX_OPEN;

  // Floor square root, built one root bit at a time from the top
  function automatic longint unsigned int_root(input longint unsigned x);
    longint unsigned r, trial;
    int b;
    r = 0;
    for (b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  // Place one car in a lane and mark the lane when it is too close ahead or behind
  function automatic void place_car(input request_t r);
    longint vx, vy, d, pos, ego, gap, proj, rv, st, lim;
    longint unsigned sq, pf;
    int lane, i;
    vx   = r.vx;
    vy   = r.vy;
    d    = r.other_d;
    sq   = vx * vx + vy * vy;
    pos  = longint'(r.other_s) * 1024;
    ego  = frame_ego;
    gap  = longint'(gap_cfg) * 1024;
    pf   = longint'(frame_pts) * 1024;
    // Projection ahead in 1/1024 m: points * speed / 50, rounded down
    proj = pos + longint'(int_root(sq * pf * pf) / 50);
    lane = -1;
    for (i = 0; i < 3; i++)
      if (d > 4 * i && d < 4 * i + 4) lane = i;
    if (lane >= 0) begin
      rv  = ref_vel;
      st  = step_cfg;
      lim = rv + st;
      // Ahead: projected car inside the gap and slower than the next reference speed
      if (proj > ego && proj - ego < gap && lim > 0 && longint'(sq) * 1000000 < lim * lim) begin
        marks[lane] = 1'b1;
        cap_sq      = sq[15:0];
      end
      // Behind: car at or behind ego, inside the gap
      if (pos <= ego && ego - pos < gap) begin
        marks[lane] = 1'b1;
        cap_sq      = sq[15:0];
      end
    end
  endfunction

  // Pick the lane and the new reference velocity; return the plan the block must emit
  function automatic plan_t decide_plan();
    longint v, st, up, lim;
    int lane;
    plan_t p;
    v    = ref_vel;
    st   = step_cfg;
    up   = v + st;
    lim  = lim_cfg;
    lane = cur_lane;
    if (!marks[lane]) begin
      if (up < lim) v = up;
    end else if (lane >= 1 && !marks[lane-1]) begin
      if (up < lim) v = up;
      lane = lane - 1;
    end else if (lane + 1 <= 2 && !marks[lane+1]) begin
      if (up < lim) v = up;
      lane = lane + 1;
    end else if (marks == 3'b111) begin
      // Every lane blocked: follow the capped speed, compared in squares
      if (up < 0 || up * up < longint'(cap_sq) * 1000000) v = up;
      else v = v - st;
    end else begin
      v = v - st;
    end
    if (v > VEL_TOP) v = VEL_TOP;
    else if (v < VEL_BOTTOM) v = VEL_BOTTOM;
    ref_vel    = v[17:0];
    cur_lane   = lane[1:0];
    p.lane     = cur_lane;
    p.velocity = ref_vel;
    p.mask     = marks;
    return p;
  endfunction

  // Advance the planner state by one accepted request
  task automatic absorb_request(input request_t r);
    plan_t owed;
    case (r.op)
      lcsp_pkg::OP_START: begin
        frame_pts = r.points;
        frame_ego = r.ego_s;
        marks     = '0;
      end
      lcsp_pkg::OP_CAR:    place_car(r);
      lcsp_pkg::OP_DECIDE: begin
        owed = decide_plan();
        pending_plans.insert(pending_plans.size(), owed);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINTED)
      $display("%0t ERROR %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  function automatic request_t random_request();
    request_t r;
    r.op      = 2'($urandom);
    r.points  = 6'($urandom);
    r.ego_s   = 23'($urandom);
    r.vx      = 8'($urandom);
    r.vy      = 8'($urandom);
    r.other_s = 13'($urandom);
    r.other_d = 7'($urandom);
    return r;
  endfunction

  // Drop valid, but only if it is up, so valid sees one assignment per step
  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offer one request in bursts with random gaps; hold it until it is taken
  task automatic send_request(input request_t r);
    if (burst_left <= 0) begin
      stop_offering();
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_op          <= r.op;
    in_prev_points <= r.points;
    in_ego_s       <= r.ego_s;
    in_other_vx    <= r.vx;
    in_other_vy    <= r.vy;
    in_other_s     <= r.other_s;
    in_other_d     <= r.other_d;
    in_valid       <= 1'b1;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_request(r);
    burst_left--;
    if (r.op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_start(input logic [5:0] pts, input logic [22:0] ego);
    request_t r;
    r        = random_request();
    r.op     = lcsp_pkg::OP_START;
    r.points = pts;
    r.ego_s  = ego;
    send_request(r);
  endtask

  task automatic send_car(input logic signed [7:0] vx, input logic signed [7:0] vy,
                          input logic [12:0] s, input logic signed [6:0] d);
    request_t r;
    r         = random_request();
    r.op      = lcsp_pkg::OP_CAR;
    r.vx      = vx;
    r.vy      = vy;
    r.other_s = s;
    r.other_d = d;
    send_request(r);
  endtask

  task automatic send_decide();
    request_t r;
    r    = random_request();
    r.op = lcsp_pkg::OP_DECIDE;
    send_request(r);
  endtask

  // Wait until every plan is back and any car request still at work has finished
  task automatic settle();
    stop_offering();
    burst_left = 0;
    while (pending_plans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers, the spare index last, holding valid across the writes
  task automatic apply_settings(input logic [16:0] lim, input logic [16:0] step,
                                input logic [16:0] gap);
    logic [1:0]  regs[4];
    logic [16:0] vals[4];
    int k;
    regs[0] = lcsp_pkg::CFG_SPEED_LIMIT;
    regs[1] = lcsp_pkg::CFG_VELOCITY_STEP;
    regs[2] = lcsp_pkg::CFG_GAP_DISTANCE;
    regs[3] = CFG_UNUSED;
    vals[0] = lim;
    vals[1] = step;
    vals[2] = gap;
    vals[3] = 17'($urandom);
    settle();
    for (k = 0; k < 4; k++) begin
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (regs[k])
        lcsp_pkg::CFG_SPEED_LIMIT:   lim_cfg  = vals[k];
        lcsp_pkg::CFG_VELOCITY_STEP: step_cfg = vals[k][11:0];
        lcsp_pkg::CFG_GAP_DISTANCE:  gap_cfg  = vals[k][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Put the registers back to their reset values
  task automatic apply_reset_settings();
    apply_settings(17'(lcsp_pkg::SPEED_LIMIT_RST), 17'(lcsp_pkg::VELOCITY_STEP_RST),
                   17'(lcsp_pkg::GAP_DISTANCE_RST));
  endtask

  function automatic logic signed [7:0] rand_speed();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'(int'($urandom_range(0, 40)) - 20);
  endfunction

  function automatic logic signed [6:0] rand_lateral();
    if ($urandom_range(0, 5) == 0) return 7'($urandom);
    return 7'($urandom_range(0, 12));
  endfunction

  // One frame with random content: cars clustered round ego, now and then broken
  task automatic random_frame();
    request_t noise;
    logic [22:0] ego;
    int centre, span, off, ncars;
    ego    = 23'($urandom);
    span   = int'(gap_cfg) + 8;
    if ($urandom_range(0, 9) != 0) begin
      send_start(6'($urandom), ego);
      centre = int'(ego >> 10);
    end else begin
      centre = int'(frame_ego >> 10);
    end
    ncars = $urandom_range(0, 5);
    repeat (ncars) begin
      if ($urandom_range(0, 3) == 0) off = int'($urandom_range(0, 300)) - 250;
      else off = int'($urandom_range(0, 2 * span)) - span;
      send_car(rand_speed(), rand_speed(), 13'(centre + off), rand_lateral());
    end
    if ($urandom_range(0, 15) == 0) begin
      noise = random_request();
      if ($urandom_range(0, 1) == 0) noise.op = OP_UNUSED;
      send_request(noise);
    end
    if ($urandom_range(0, 9) != 0) send_decide();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Car before any start uses the reset frame latches; marks outlive the decide
  task automatic test_car_before_start();
    request_t r;
    send_car(8'sd0, 8'sd0, 13'd0, 7'sd2);
    r    = random_request();
    r.op = OP_UNUSED;
    send_request(r);
    send_decide();
    send_decide();
  endtask

  // Extreme positions and speeds, lane boundaries and out-of-road offsets
  task automatic test_field_extremes();
    send_start(6'd63, 23'h7FFFFF);
    send_car(-8'sd128, -8'sd128, 13'h1FFF, 7'sd2);
    send_car(8'sd127, 8'sd127, 13'h1FFF, 7'sd63);
    send_car(8'sd127, -8'sd128, 13'd0, -7'sd64);
    send_car(-8'sd128, 8'sd127, 13'h1FFF, 7'sd4);
    send_car(8'sd0, 8'sd0, 13'h1FFF, 7'sd8);
    send_car(8'sd5, -8'sd3, 13'h1FFF, 7'sd12);
    send_car(8'sd0, 8'sd0, 13'h1FFF, 7'sd11);
    send_decide();
    send_start(6'd0, 23'd0);
    send_car(8'sd127, 8'sd127, 13'd0, 7'sd5);
    send_decide();
  endtask

  // All three lanes blocked, one of them by a car projected ahead: follow the cap
  task automatic test_follow_capped();
    send_start(6'd10, 23'(100 * 1024));
    send_car(8'sd30, 8'sd40, 13'd100, 7'sd1);
    send_car(8'sd0, 8'sd0, 13'd101, 7'sd6);
    send_car(8'sd30, 8'sd40, 13'd100, 7'sd9);
    send_decide();
  endtask

  // Drive the reference velocity onto both rails with the largest step
  task automatic test_velocity_rails();
    apply_settings(17'h1FFFF, 17'hFFF, 17'd30);
    // Block the current lane and its only free neighbour: slow down frame after frame
    repeat (48) begin
      send_start(6'd0, 23'(2000 * 1024));
      if (cur_lane == 2'd2) send_car(8'sd0, 8'sd0, 13'd2000, 7'sd10);
      else send_car(8'sd0, 8'sd0, 13'd2000, 7'sd2);
      send_car(8'sd0, 8'sd0, 13'd2000, 7'sd6);
      send_decide();
    end
    // Block every lane with the fastest car last: the cap lets speed climb to the top
    repeat (68) begin
      send_start(6'd0, 23'(2000 * 1024));
      send_car(8'sd0, 8'sd0, 13'd2000, 7'sd2);
      send_car(8'sd0, 8'sd0, 13'd2000, 7'sd6);
      send_car(-8'sd128, -8'sd128, 13'd2000, 7'sd10);
      send_decide();
    end
  endtask

  // Hold the receiver off while frames keep coming, so a waiting plan stalls requests
  task automatic test_backpressure();
    apply_reset_settings();
    holdoff_request = HOLDOFF_LEN;
    burst_left      = 1000;
    repeat (5) begin
      send_start(6'($urandom), 23'($urandom));
      send_car(rand_speed(), rand_speed(), 13'($urandom), rand_lateral());
      send_decide();
    end
    burst_left = 0;
  endtask

  // Random frames under a sequence of register settings, extremes first
  task automatic test_random_traffic();
    int phase;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 6)
        0: apply_settings(17'h1FFFF, 17'hFFF, 17'hFF);
        1: apply_settings(17'd0, 17'd0, 17'd0);
        2: apply_reset_settings();
        3: apply_settings(17'($urandom), 17'($urandom), 17'($urandom));
        4: apply_settings(17'($urandom_range(20000, 80000)), 17'($urandom_range(100, 1500)),
                          17'($urandom_range(10, 60)));
        default: apply_settings(17'($urandom), 17'($urandom_range(0, 4095)),
                                17'($urandom_range(0, 255)));
      endcase
      repeat (50) begin
        if (items_sent < ITEM_TARGET) random_frame();
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus a long hold-off when a test asks
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holdoff_request > 0) begin
      holdoff_left    = holdoff_request;
      holdoff_request = 0;
    end
    if (holdoff_left > 0) begin
      out_ready <= 1'b0;
      holdoff_left--;
    end else begin
      if (rx_stretch <= 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        rx_stretch = $urandom_range(4, 64);
      end
      rx_stretch--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Compare each collected result with the oldest plan owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_plans.size() == 0) begin
        report_mismatch("result with no decide pending", out_next_velocity, 0);
      end else begin
        head_plan = pending_plans.pop_front();
        if (out_next_lane !== head_plan.lane)
          report_mismatch("next_lane", out_next_lane, head_plan.lane);
        if (out_next_velocity !== head_plan.velocity)
          report_mismatch("next_velocity", out_next_velocity, head_plan.velocity);
        if (out_occupied_mask !== head_plan.mask)
          report_mismatch("occupied_mask", out_occupied_mask, head_plan.mask);
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("lane_change_speed_planner: mismatch");
      $finish;
    end
  end

  initial begin
    in_valid       = 1'b0;
    in_op          = lcsp_pkg::OP_START;
    in_prev_points = '0;
    in_ego_s       = '0;
    in_other_vx    = '0;
    in_other_vy    = '0;
    in_other_s     = '0;
    in_other_d     = '0;
    cfg_valid      = 1'b0;
    cfg_index      = lcsp_pkg::CFG_SPEED_LIMIT;
    cfg_data       = '0;
    rst_n          = 1'b0;

    // Initialise the tracked state to its reset values
    lim_cfg   = lcsp_pkg::SPEED_LIMIT_RST;
    step_cfg  = lcsp_pkg::VELOCITY_STEP_RST;
    gap_cfg   = lcsp_pkg::GAP_DISTANCE_RST;
    cur_lane  = 2'd1;
    ref_vel   = '0;
    cap_sq    = '0;
    marks     = '0;
    frame_ego = '0;
    frame_pts = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_car_before_start();
    test_field_extremes();
    test_follow_capped();
    test_velocity_rails();
    test_backpressure();
    test_random_traffic();

    settle();
    if (mismatches == 0)
      $display("lane_change_speed_planner: match");
    else
      $display("lane_change_speed_planner: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lcsp_pkg.sv
rtl/lcsp_isqrt.sv
rtl/lane_change_speed_planner.sv
verif/lane_change_speed_planner_tb.sv
